### rtl/core/lchi_pkg.sv
package lchi_pkg;

	localparam int LVL_MAX    = 8;
	localparam int LVL_W      = $clog2(LVL_MAX);
	localparam int NLVL_W     = 4;
	localparam int SAMPLE_W   = 16;
	localparam int POS_W      = 17;
	localparam int FRAC_W     = 16;
	localparam int GRAY_W     = 8;
	localparam int GSCALED_W  = GRAY_W + FRAC_W;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 64;
	localparam int DIST_W     = 18;
	localparam int DIV_STAGES = 8;
	localparam int DIV_BITS   = FRAC_W / DIV_STAGES;
	localparam int TAN_W      = SAMPLE_W + 2;
	localparam int WGT_W      = 20;
	localparam int PROD_W     = WGT_W + TAN_W;
	localparam int SUM_W      = PROD_W + 2;
	localparam int RND_W      = SUM_W - 18;

	localparam logic [POS_W-1:0]        ONE_Q16  = POS_W'(1) << FRAC_W;
	localparam logic signed [TAN_W-1:0] M1_OVR_Q = TAN_W'(1024);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_NUM_LEVELS   = 2'd0,
		CFG_INDEXED_MODE = 2'd1,
		CFG_GRAY_VALUES  = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [NLVL_W-1:0]     num_levels;
		logic                  indexed_mode;
		logic [CFG_DATA_W-1:0] gray_values;
	} cfg_t;

	// one classified pixel, handed from front to back
	typedef struct packed {
		logic                       need_div;
		logic [POS_W-1:0]           t_direct;
		logic [GSCALED_W-1:0]       num;
		logic [GRAY_W-1:0]          den;
		logic signed [SAMPLE_W-1:0] sm;
		logic signed [SAMPLE_W-1:0] s0;
		logic signed [SAMPLE_W-1:0] s1;
		logic signed [SAMPLE_W-1:0] s2;
		logic                       m0_half;
		logic                       m1_half;
		logic                       over;
	} qent_t;

endpackage

### rtl/core/lchi_if.sv
interface lchi_pixel_if;
	logic                                valid;
	logic                                ready;
	logic [lchi_pkg::POS_W-1:0]          position;
	logic signed [lchi_pkg::SAMPLE_W-1:0] level_sample_0;
	logic signed [lchi_pkg::SAMPLE_W-1:0] level_sample_1;
	logic signed [lchi_pkg::SAMPLE_W-1:0] level_sample_2;
	logic signed [lchi_pkg::SAMPLE_W-1:0] level_sample_3;
	logic signed [lchi_pkg::SAMPLE_W-1:0] level_sample_4;
	logic signed [lchi_pkg::SAMPLE_W-1:0] level_sample_5;
	logic signed [lchi_pkg::SAMPLE_W-1:0] level_sample_6;
	logic signed [lchi_pkg::SAMPLE_W-1:0] level_sample_7;

	modport source (output valid, position, level_sample_0, level_sample_1, level_sample_2,
		level_sample_3, level_sample_4, level_sample_5, level_sample_6, level_sample_7,
		input ready);
	modport sink (input valid, position, level_sample_0, level_sample_1, level_sample_2,
		level_sample_3, level_sample_4, level_sample_5, level_sample_6, level_sample_7,
		output ready);
endinterface

interface lchi_result_if;
	logic                               valid;
	logic                               ready;
	logic signed [lchi_pkg::DIST_W-1:0] distance;
	logic                               saturated;

	modport source (output valid, distance, saturated, input ready);
	modport sink (input valid, distance, saturated, output ready);
endinterface

interface lchi_csr_if;
	logic                               valid;
	logic                               ready;
	logic [lchi_pkg::CFG_IDX_W-1:0]     index;
	logic [lchi_pkg::CFG_DATA_W-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### rtl/core/layered_cubic_hermite_interp.sv
// Channel  Dir  Word
// pixel    in   position, level_sample_0..7
// result   out  distance, saturated
// csr      in   index, data (register write)
//
// One pixel per clock while the result side takes each word; a pixel is written into the queue,
// then passes the 8 divider stages, the square, cube, weight and product stages and the
// rounded output register. Every pixel takes the divider stages, indexed or not.
// Reset (arst_n low) empties the queue and pipe and loads the register defaults.
// A stalled result freezes the back pipe; the 2-word queue takes pixels until full.
// csr is always ready.
module layered_cubic_hermite_interp (
	input  logic          clk,
	input  logic          arst_n,
	lchi_pixel_if.sink    pixel,
	lchi_result_if.source result,
	lchi_csr_if.sink      csr
);

	lchi_pkg::cfg_t  cfg_q;
	lchi_pkg::qent_t entry, head;
	logic            push, full, pop, not_empty;

	assign csr.ready = 1'b1;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.num_levels   <= lchi_pkg::NLVL_W'(lchi_pkg::LVL_MAX);
			cfg_q.indexed_mode <= 1'b0;
			cfg_q.gray_values  <= '0;
		end else if (csr.valid) begin
			case (lchi_pkg::cfg_idx_t'(csr.index))
				lchi_pkg::CFG_NUM_LEVELS:
					cfg_q.num_levels <= csr.data[lchi_pkg::NLVL_W-1:0];
				lchi_pkg::CFG_INDEXED_MODE:
					cfg_q.indexed_mode <= csr.data[0];
				lchi_pkg::CFG_GRAY_VALUES:
					cfg_q.gray_values <= csr.data;
				default: begin
				end
			endcase
		end
	end

	lchi_front u_front (
		.pixel  (pixel),
		.cfg    (cfg_q),
		.q_full (full),
		.push   (push),
		.entry  (entry)
	);

	lchi_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_entry  (entry),
		.full      (full),
		.pop       (pop),
		.not_empty (not_empty),
		.head      (head)
	);

	lchi_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (not_empty),
		.head    (head),
		.pop     (pop),
		.result  (result)
	);

endmodule

### rtl/core/lchi_front.sv
module lchi_front (
	lchi_pixel_if.sink           pixel,
	input  lchi_pkg::cfg_t       cfg,
	input  logic                 q_full,
	output logic                 push,
	output lchi_pkg::qent_t      entry
);

	logic [lchi_pkg::NLVL_W-1:0]    n;
	logic [lchi_pkg::LVL_W-1:0]     nm1;
	logic [lchi_pkg::POS_W-1:0]     p;
	logic [lchi_pkg::POS_W+lchi_pkg::LVL_W-1:0] su;
	logic [lchi_pkg::GSCALED_W-1:0] g;
	logic [lchi_pkg::GRAY_W-1:0]    gv [lchi_pkg::LVL_MAX];
	logic signed [lchi_pkg::SAMPLE_W-1:0] smp [lchi_pkg::LVL_MAX];
	logic [lchi_pkg::LVL_W-1:0]     l0, l0i, l1, lm, l2;
	logic                           found, over, zero_t, clip_t;
	logic [lchi_pkg::GRAY_W-1:0]    v0, v1, den;
	logic [lchi_pkg::GSCALED_W-1:0] g0, num;

	assign pixel.ready = !q_full;
	assign push        = pixel.valid && !q_full;

	assign smp[0] = pixel.level_sample_0;
	assign smp[1] = pixel.level_sample_1;
	assign smp[2] = pixel.level_sample_2;
	assign smp[3] = pixel.level_sample_3;
	assign smp[4] = pixel.level_sample_4;
	assign smp[5] = pixel.level_sample_5;
	assign smp[6] = pixel.level_sample_6;
	assign smp[7] = pixel.level_sample_7;

	for (genvar i = 0; i < lchi_pkg::LVL_MAX; i++) begin : g_gray
		assign gv[i] = cfg.gray_values[i*lchi_pkg::GRAY_W +: lchi_pkg::GRAY_W];
	end

	// clamp level count and position
	always_comb begin
		if (cfg.num_levels < lchi_pkg::NLVL_W'(2))
			n = lchi_pkg::NLVL_W'(2);
		else if (cfg.num_levels > lchi_pkg::NLVL_W'(lchi_pkg::LVL_MAX))
			n = lchi_pkg::NLVL_W'(lchi_pkg::LVL_MAX);
		else
			n = cfg.num_levels;
		nm1 = lchi_pkg::LVL_W'(n - lchi_pkg::NLVL_W'(1));
		p   = (pixel.position > lchi_pkg::ONE_Q16) ? lchi_pkg::ONE_Q16 : pixel.position;
		su  = (lchi_pkg::POS_W+lchi_pkg::LVL_W)'(p) * nm1;
		g   = lchi_pkg::GSCALED_W'({p, 8'b0} - {8'b0, p});
	end

	// bracketing interval search in the gray table
	always_comb begin
		found = 1'b0;
		l0i   = '0;
		for (int i = 0; i < lchi_pkg::LVL_MAX-1; i++) begin
			if (!found && (lchi_pkg::NLVL_W'(i + 1) < n)
				&& (g >= {gv[i], 16'b0}) && (g <= {gv[i+1], 16'b0})) begin
				l0i   = lchi_pkg::LVL_W'(i);
				found = 1'b1;
			end
		end
		if (!found)
			l0i = (g >= {gv[nm1], 16'b0}) ? nm1 : '0;
	end

	// neighbor levels and fraction
	always_comb begin
		l0 = cfg.indexed_mode ? l0i : su[lchi_pkg::FRAC_W +: lchi_pkg::LVL_W];
		l1 = (({1'b0, l0} + 4'd1) < {1'b0, nm1}) ? l0 + 1'b1 : nm1;
		l2 = (({1'b0, l1} + 4'd1) < {1'b0, nm1}) ? l1 + 1'b1 : nm1;
		lm = (l0 != '0) ? l0 - 1'b1 : '0;
		if (cfg.indexed_mode)
			over = ({1'b0, l1} + 4'd1) >= n;
		else
			over = ({1'b0, l1} + 4'd1) >= {1'b0, nm1};

		v0     = gv[l0];
		v1     = gv[l1];
		g0     = {v0, 16'b0};
		num    = g - g0;
		den    = v1 - v0;
		zero_t = (v1 <= v0) || (g <= g0);
		clip_t = num >= {den, 16'b0};

		entry          = '0;
		entry.sm       = smp[lm];
		entry.s0       = smp[l0];
		entry.s1       = smp[l1];
		entry.s2       = smp[l2];
		entry.m0_half  = (l1 - lm) == lchi_pkg::LVL_W'(2);
		entry.m1_half  = (l2 - l0) == lchi_pkg::LVL_W'(2);
		entry.over     = over;
		entry.den      = den;
		if (!cfg.indexed_mode) begin
			entry.t_direct = {1'b0, su[lchi_pkg::FRAC_W-1:0]};
		end else if (zero_t) begin
			entry.t_direct = '0;
		end else if (clip_t) begin
			entry.t_direct = lchi_pkg::ONE_Q16;
		end else begin
			entry.need_div = 1'b1;
			entry.num      = num;
		end
	end

endmodule

### rtl/core/lchi_queue.sv
module lchi_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  lchi_pkg::qent_t wr_entry,
	output logic            full,
	input  logic            pop,
	output logic            not_empty,
	output lchi_pkg::qent_t head
);

	lchi_pkg::qent_t mem_q [2];
	logic            wr_ptr_q, rd_ptr_q;
	logic [1:0]      cnt_q;

	assign full      = cnt_q == 2'd2;
	assign not_empty = cnt_q != 2'd0;
	assign head      = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			if (push && !pop)
				cnt_q <= cnt_q + 2'd1;
			else if (pop && !push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_entry;
	end

endmodule

### rtl/core/lchi_back.sv
module lchi_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	input  lchi_pkg::qent_t head,
	output logic            pop,
	lchi_result_if.source   result
);

	typedef struct packed {
		lchi_pkg::qent_t                 e;
		logic [lchi_pkg::GSCALED_W-1:0] rem;
		logic [lchi_pkg::FRAC_W-1:0]    quo;
	} div_t;

	typedef struct packed {
		logic [lchi_pkg::POS_W-1:0]        t;
		logic [lchi_pkg::POS_W-1:0]        t2;
		logic [lchi_pkg::POS_W-1:0]        t3;
		logic signed [lchi_pkg::TAN_W-1:0] s0x4;
		logic signed [lchi_pkg::TAN_W-1:0] s1x4;
		logic signed [lchi_pkg::TAN_W-1:0] m0q;
		logic signed [lchi_pkg::TAN_W-1:0] m1q;
	} poly_t;

	logic en;
	div_t div_in [lchi_pkg::DIV_STAGES];
	div_t div_nx [lchi_pkg::DIV_STAGES];
	div_t div_s  [lchi_pkg::DIV_STAGES];
	logic [lchi_pkg::DIV_STAGES-1:0] dvld_s;

	poly_t pt2_nx, pt2_s2, pt3_nx, pt3_s3;
	logic  v_s2, v_s3, v_s4, v_s5;
	logic signed [lchi_pkg::WGT_W-1:0]  b0_s4, b1_s4, b2_s4, b3_s4;
	logic signed [lchi_pkg::TAN_W-1:0]  s0_s4, s1_s4, m0_s4, m1_s4;
	logic signed [lchi_pkg::PROD_W-1:0] pr0_s5, pr1_s5, pr2_s5, pr3_s5;
	logic signed [lchi_pkg::SUM_W-1:0]  sum;
	logic signed [lchi_pkg::RND_W-1:0]  rnd;
	logic signed [lchi_pkg::DIST_W-1:0] dist_q;
	logic                               sat_q, out_vld_q;
	logic [2*lchi_pkg::POS_W-1:0]       sq, cu;
	logic signed [lchi_pkg::SAMPLE_W:0] d0, d1;

	// whole pipe moves unless the output word is stuck
	assign en  = !out_vld_q || result.ready;
	assign pop = q_valid && en;

	assign result.valid     = out_vld_q;
	assign result.distance  = dist_q;
	assign result.saturated = sat_q;

	// restoring divider, DIV_BITS quotient bits per stage
	for (genvar k = 0; k < lchi_pkg::DIV_STAGES; k++) begin : g_div
		if (k == 0) begin : g_head
			assign div_in[k] = '{e: head, rem: head.num, quo: '0};
		end else begin : g_link
			assign div_in[k] = div_s[k-1];
		end

		always_comb begin
			logic [lchi_pkg::GSCALED_W-1:0] r;
			logic [lchi_pkg::GSCALED_W-1:0] sh;
			logic [lchi_pkg::FRAC_W-1:0]    qv;
			r  = div_in[k].rem;
			qv = div_in[k].quo;
			for (int j = 0; j < lchi_pkg::DIV_BITS; j++) begin
				sh = lchi_pkg::GSCALED_W'(div_in[k].e.den)
					<< (lchi_pkg::FRAC_W - 1 - lchi_pkg::DIV_BITS*k - j);
				if (r >= sh) begin
					r = r - sh;
					qv[4'(lchi_pkg::FRAC_W - 1 - lchi_pkg::DIV_BITS*k - j)] = 1'b1;
				end
			end
			div_nx[k]     = div_in[k];
			div_nx[k].rem = r;
			div_nx[k].quo = qv;
		end

		always_ff @(posedge clk) begin
			if (en)
				div_s[k] <= div_nx[k];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				dvld_s[k] <= 1'b0;
			else if (en)
				dvld_s[k] <= (k == 0) ? q_valid : dvld_s[(k == 0) ? 0 : k-1];
		end
	end

	// fraction select, square and tangents
	always_comb begin
		lchi_pkg::qent_t e;
		e = div_s[lchi_pkg::DIV_STAGES-1].e;
		pt2_nx    = '0;
		pt2_nx.t  = e.need_div ? {1'b0, div_s[lchi_pkg::DIV_STAGES-1].quo} : e.t_direct;
		sq        = pt2_nx.t * pt2_nx.t;
		pt2_nx.t2 = sq[lchi_pkg::FRAC_W +: lchi_pkg::POS_W];
		pt2_nx.s0x4 = {e.s0, 2'b0};
		pt2_nx.s1x4 = {e.s1, 2'b0};
		d0 = {e.s1[lchi_pkg::SAMPLE_W-1], e.s1} - {e.sm[lchi_pkg::SAMPLE_W-1], e.sm};
		d1 = {e.s2[lchi_pkg::SAMPLE_W-1], e.s2} - {e.s0[lchi_pkg::SAMPLE_W-1], e.s0};
		pt2_nx.m0q = e.m0_half ? lchi_pkg::TAN_W'(d0) : {d0, 1'b0};
		if (e.over)
			pt2_nx.m1q = lchi_pkg::M1_OVR_Q;
		else
			pt2_nx.m1q = e.m1_half ? lchi_pkg::TAN_W'(d1) : {d1, 1'b0};
	end

	assign cu = pt2_s2.t2 * pt2_s2.t;

	// cube joins the carried fields
	always_comb begin
		pt3_nx    = pt2_s2;
		pt3_nx.t3 = cu[lchi_pkg::FRAC_W +: lchi_pkg::POS_W];
	end

	// final sum and round half up; the clip follows in the output register
	always_comb begin
		sum = lchi_pkg::SUM_W'(pr0_s5) + lchi_pkg::SUM_W'(pr1_s5)
			+ lchi_pkg::SUM_W'(pr2_s5) + lchi_pkg::SUM_W'(pr3_s5)
			+ lchi_pkg::SUM_W'(1 << 17);
		rnd = lchi_pkg::RND_W'(sum >>> 18);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pt2_s2 <= pt2_nx;

			pt3_s3 <= pt3_nx;

			// Hermite basis weights
			b0_s4 <= lchi_pkg::WGT_W'(2*pt3_s3.t3) - lchi_pkg::WGT_W'(3*pt3_s3.t2)
				+ lchi_pkg::WGT_W'(lchi_pkg::ONE_Q16);
			b1_s4 <= lchi_pkg::WGT_W'(pt3_s3.t3) - lchi_pkg::WGT_W'(2*pt3_s3.t2)
				+ lchi_pkg::WGT_W'(pt3_s3.t);
			b2_s4 <= lchi_pkg::WGT_W'(3*pt3_s3.t2) - lchi_pkg::WGT_W'(2*pt3_s3.t3);
			b3_s4 <= lchi_pkg::WGT_W'(pt3_s3.t3) - lchi_pkg::WGT_W'(pt3_s3.t2);
			s0_s4 <= pt3_s3.s0x4;
			s1_s4 <= pt3_s3.s1x4;
			m0_s4 <= pt3_s3.m0q;
			m1_s4 <= pt3_s3.m1q;

			pr0_s5 <= b0_s4 * s0_s4;
			pr1_s5 <= b1_s4 * m0_s4;
			pr2_s5 <= b2_s4 * s1_s4;
			pr3_s5 <= b3_s4 * m1_s4;

			if (rnd > lchi_pkg::RND_W'(131071)) begin
				dist_q <= lchi_pkg::DIST_W'(131071);
				sat_q  <= 1'b1;
			end else if (rnd < -lchi_pkg::RND_W'(131072)) begin
				dist_q <= lchi_pkg::DIST_W'(-131072);
				sat_q  <= 1'b1;
			end else begin
				dist_q <= lchi_pkg::DIST_W'(rnd);
				sat_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			v_s5      <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (en) begin
			v_s2      <= dvld_s[lchi_pkg::DIV_STAGES-1];
			v_s3      <= v_s2;
			v_s4      <= v_s3;
			v_s5      <= v_s4;
			out_vld_q <= v_s5;
		end
	end

endmodule

### tb/layered_cubic_hermite_interp_tb.sv
module layered_cubic_hermite_interp_tb;

	typedef struct {
		logic [lchi_pkg::POS_W-1:0]           position;
		logic signed [lchi_pkg::SAMPLE_W-1:0] smp [lchi_pkg::LVL_MAX];
	} pixel_t;

	typedef struct {
		logic signed [lchi_pkg::DIST_W-1:0] distance;
		logic                               saturated;
	} dist_t;

	// directed rows: pixel plus optional hand-typed expectation
	typedef struct {
		logic [lchi_pkg::POS_W-1:0]           position;
		logic signed [lchi_pkg::SAMPLE_W-1:0] fill;
		logic                                 typed;
		logic signed [lchi_pkg::DIST_W-1:0]   distance;
		logic                                 saturated;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   cycle_cnt = 0;
	int   fail_cnt = 0;
	bit   stim_done = 1'b0;
	bit   hold_rx = 1'b0;

	lchi_pixel_if  pix_ch ();
	lchi_result_if res_ch ();
	lchi_csr_if    csr_ch ();

	layered_cubic_hermite_interp dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pixel  (pix_ch.sink),
		.result (res_ch.source),
		.csr    (csr_ch.sink)
	);

	// local copy of the registers
	logic [lchi_pkg::NLVL_W-1:0]     lvl_cnt;
	logic                            idx_mode;
	logic [lchi_pkg::CFG_DATA_W-1:0] gray_tbl;

	dist_t dist_q [$];

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > 400000) begin
			$display("simulation failed");
			$finish;
		end
	end

	function automatic longint gray_at(int i);
		return longint'((gray_tbl >> (i * 8)) & 64'hFF);
	endfunction

	// expected blend for one pixel under the current registers
	function automatic dist_t blend_pixel(pixel_t px);
		int n, l0, lm, l1, l2, i;
		longint p, sc, g, t, t2, t3, v0, v1;
		longint sm, s0, s1, s2, m0q, m1q, b0, b1, b2, b3, sum, r;
		bit over, found;
		dist_t res;
		n = lvl_cnt;
		if (n < 2) n = 2;
		if (n > lchi_pkg::LVL_MAX) n = lchi_pkg::LVL_MAX;
		p = px.position;
		if (p > 65536) p = 65536;
		if (!idx_mode) begin
			sc = p * (n - 1);
			l0 = int'(sc >>> 16);
			if (l0 > n - 1) l0 = n - 1;
			t = sc & 16'hFFFF;
			l1 = (l0 + 1 < n - 1) ? l0 + 1 : n - 1;
			over = (l1 + 1 >= n - 1);
		end else begin
			g = p * 255;
			found = 1'b0;
			l0 = 0;
			for (i = 0; i + 1 < n; i++) begin
				if (!found && g >= (gray_at(i) << 16) && g <= (gray_at(i + 1) << 16)) begin
					l0 = i;
					found = 1'b1;
				end
			end
			if (!found) l0 = (g >= (gray_at(n - 1) << 16)) ? n - 1 : 0;
			l1 = (l0 + 1 < n - 1) ? l0 + 1 : n - 1;
			v0 = gray_at(l0);
			v1 = gray_at(l1);
			if (v1 <= v0 || g <= (v0 << 16)) t = 0;
			else begin
				t = (g - (v0 << 16)) / (v1 - v0);
				if (t > 65536) t = 65536;
			end
			over = (l1 + 1 >= n);
		end
		lm = (l0 > 0) ? l0 - 1 : 0;
		l2 = (l1 + 1 < n - 1) ? l1 + 1 : n - 1;
		sm = px.smp[lm];
		s0 = px.smp[l0];
		s1 = px.smp[l1];
		s2 = px.smp[l2];
		m0q = (s1 - sm) * ((l1 - lm == 2) ? 1 : 2);
		m1q = over ? 1024 : (s2 - s0) * ((l2 - l0 == 2) ? 1 : 2);
		t2 = (t * t) >>> 16;
		t3 = (t2 * t) >>> 16;
		b0 = 2 * t3 - 3 * t2 + 65536;
		b1 = t3 - 2 * t2 + t;
		b2 = -2 * t3 + 3 * t2;
		b3 = t3 - t2;
		sum = b0 * (s0 * 4) + b1 * m0q + b2 * (s1 * 4) + b3 * m1q;
		r = (sum + (longint'(1) << 17)) >>> 18;
		res.saturated = 1'b0;
		if (r > 131071) begin
			r = 131071;
			res.saturated = 1'b1;
		end
		if (r < -131072) begin
			r = -131072;
			res.saturated = 1'b1;
		end
		res.distance = r[lchi_pkg::DIST_W-1:0];
		return res;
	endfunction

	// drop valid only when a gap really follows
	task automatic idle_gap();
		int k;
		k = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
		if ($urandom_range(0, 3) == 0) k = 0;
		if (k != 0) begin
			pix_ch.valid <= 1'b0;
			repeat (k) @(posedge clk);
		end
	endtask

	task automatic write_reg(lchi_pkg::cfg_idx_t idx, logic [lchi_pkg::CFG_DATA_W-1:0] val);
		csr_ch.valid <= 1'b1;
		csr_ch.index <= idx;
		csr_ch.data  <= val;
		do @(posedge clk); while (!csr_ch.ready);
		csr_ch.valid <= 1'b0;
		case (idx)
			lchi_pkg::CFG_NUM_LEVELS:   lvl_cnt  = val[lchi_pkg::NLVL_W-1:0];
			lchi_pkg::CFG_INDEXED_MODE: idx_mode = val[0];
			lchi_pkg::CFG_GRAY_VALUES:  gray_tbl = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	// drain outstanding results, then let the pipe settle
	task automatic wait_idle();
		while (dist_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic send_pixel(pixel_t px, bit typed, dist_t want);
		pix_ch.valid    <= 1'b1;
		pix_ch.position <= px.position;
		pix_ch.level_sample_0 <= px.smp[0];
		pix_ch.level_sample_1 <= px.smp[1];
		pix_ch.level_sample_2 <= px.smp[2];
		pix_ch.level_sample_3 <= px.smp[3];
		pix_ch.level_sample_4 <= px.smp[4];
		pix_ch.level_sample_5 <= px.smp[5];
		pix_ch.level_sample_6 <= px.smp[6];
		pix_ch.level_sample_7 <= px.smp[7];
		do @(posedge clk); while (!pix_ch.ready);
		dist_q.push_back(typed ? want : blend_pixel(px));
	endtask

	task automatic drop_valid();
		pix_ch.valid <= 1'b0;
	endtask

	function automatic pixel_t rand_pixel(bit narrow);
		pixel_t px;
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) px.position = 17'(65536);
		else if (r == 1) px.position = 17'($urandom_range(65537, 131071));
		else if (r == 2) px.position = 17'(0);
		else px.position = 17'($urandom_range(0, 65535));
		for (int i = 0; i < lchi_pkg::LVL_MAX; i++) begin
			if (narrow) px.smp[i] = lchi_pkg::SAMPLE_W'($urandom_range(0, 4095) - 2048);
			else px.smp[i] = lchi_pkg::SAMPLE_W'($urandom);
		end
		return px;
	endfunction

	// ascending gray table, sometimes unsorted or with repeats
	function automatic logic [lchi_pkg::CFG_DATA_W-1:0] rand_gray();
		logic [lchi_pkg::CFG_DATA_W-1:0] v;
		int g;
		g = $urandom_range(0, 20);
		for (int i = 0; i < lchi_pkg::LVL_MAX; i++) begin
			v[i*8 +: 8] = 8'(g);
			g = g + $urandom_range(0, 45);
			if (g > 255) g = 255;
		end
		if ($urandom_range(0, 4) == 0) v = {$urandom, $urandom};
		return v;
	endfunction

	// stimulus
	initial begin
		row_t   rows [12];
		pixel_t px;
		dist_t  want;
		int     nlv;
		pix_ch.valid <= 1'b0;
		pix_ch.position <= '0;
		pix_ch.level_sample_0 <= '0;
		pix_ch.level_sample_1 <= '0;
		pix_ch.level_sample_2 <= '0;
		pix_ch.level_sample_3 <= '0;
		pix_ch.level_sample_4 <= '0;
		pix_ch.level_sample_5 <= '0;
		pix_ch.level_sample_6 <= '0;
		pix_ch.level_sample_7 <= '0;
		csr_ch.valid <= 1'b0;
		csr_ch.index <= lchi_pkg::CFG_NUM_LEVELS;
		csr_ch.data  <= '0;
		lvl_cnt  = 4'd8;
		idx_mode = 1'b0;
		gray_tbl = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// flat samples at t=0 give the sample back; typed where obvious
		rows[0]  = '{17'd0,      16'sh7FFF, 1'b1, 18'sh07FFF, 1'b0};
		rows[1]  = '{17'd0,      16'sh8000, 1'b1, -18'sh08000, 1'b0};
		rows[2]  = '{17'd0,      16'sh0000, 1'b1, 18'sh00000, 1'b0};
		rows[3]  = '{17'd65536,  16'sh0100, 1'b0, '0, 1'b0};
		rows[4]  = '{17'd131071, 16'sh0100, 1'b0, '0, 1'b0};
		rows[5]  = '{17'd32768,  16'sh7FFF, 1'b0, '0, 1'b0};
		rows[6]  = '{17'd9362,   16'sh8000, 1'b0, '0, 1'b0};
		rows[7]  = '{17'd65535,  16'sh0001, 1'b0, '0, 1'b0};
		rows[8]  = '{17'd1,      16'shFFFF, 1'b0, '0, 1'b0};
		rows[9]  = '{17'd56173,  16'sh1234, 1'b0, '0, 1'b0};
		rows[10] = '{17'd65536,  16'sh7FFF, 1'b0, '0, 1'b0};
		rows[11] = '{17'd70000,  16'sh8000, 1'b0, '0, 1'b0};
		foreach (rows[i]) begin
			px.position = rows[i].position;
			for (int k = 0; k < lchi_pkg::LVL_MAX; k++) px.smp[k] = rows[i].fill;
			want.distance  = rows[i].distance;
			want.saturated = rows[i].saturated;
			send_pixel(px, rows[i].typed, want);
		end
		// alternating extremes to push the blend into saturation
		for (int i = 0; i < 6; i++) begin
			px.position = 17'(i * 13107);
			for (int k = 0; k < lchi_pkg::LVL_MAX; k++)
				px.smp[k] = k[0] ? 16'sh7FFF : 16'sh8000;
			send_pixel(px, 1'b0, want);
		end
		drop_valid();
		wait_idle();

		// indexed mode: zero table, repeated values, below-first-level
		write_reg(lchi_pkg::CFG_INDEXED_MODE, 64'd1);
		for (int i = 0; i < 3; i++) begin
			px = rand_pixel(1'b0);
			send_pixel(px, 1'b0, want);
		end
		drop_valid();
		wait_idle();
		write_reg(lchi_pkg::CFG_GRAY_VALUES, 64'hFFE0_C0A0_8060_4030);
		for (int i = 0; i < 4; i++) begin
			px = rand_pixel(1'b0);
			px.position = (i == 0) ? 17'd0 : 17'(i * 21845);
			send_pixel(px, 1'b0, want);
		end
		drop_valid();
		wait_idle();

		// random phases over register settings, extremes included
		for (int ph = 0; ph < 14; ph++) begin
			if (ph == 0) nlv = 2;
			else if (ph == 1) nlv = 8;
			else if (ph == 2) nlv = 0;
			else if (ph == 3) nlv = 15;
			else nlv = $urandom_range(0, 15);
			write_reg(lchi_pkg::CFG_NUM_LEVELS, 64'(nlv));
			write_reg(lchi_pkg::CFG_INDEXED_MODE, 64'(ph % 2));
			write_reg(lchi_pkg::CFG_GRAY_VALUES,
				(ph == 5) ? 64'hFFFF_FFFF_FFFF_FFFF : rand_gray());
			for (int i = 0; i < 125; i++) begin
				px = rand_pixel($urandom_range(0, 2) == 0);
				send_pixel(px, 1'b0, want);
				if ($urandom_range(0, 2) == 0)
					idle_gap();
			end
			drop_valid();
			wait_idle();
		end
		stim_done = 1'b1;
	end

	// long hold-off once, early in the random part
	initial begin
		wait (cycle_cnt == 900);
		hold_rx = 1'b1;
		repeat (200) @(posedge clk);
		hold_rx = 1'b0;
	end

	// result side: random stalls, compare against oldest expectation
	initial begin
		dist_t w;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (res_ch.valid && res_ch.ready) begin
				if (dist_q.size() == 0) begin
					$display("%0t: unexpected word distance=%0d sat=%0b", $time,
						res_ch.distance, res_ch.saturated);
					fail_cnt++;
				end else begin
					w = dist_q.pop_front();
					if (res_ch.distance !== w.distance) begin
						$display("%0t: distance expected %0d actual %0d", $time,
							w.distance, res_ch.distance);
						fail_cnt++;
					end
					if (res_ch.saturated !== w.saturated) begin
						$display("%0t: saturated expected %0b actual %0b", $time,
							w.saturated, res_ch.saturated);
						fail_cnt++;
					end
				end
			end
			if (hold_rx) res_ch.ready <= 1'b0;
			else if ($urandom_range(0, 19) == 0) res_ch.ready <= 1'b0;
			else if ($urandom_range(0, 3) == 0) res_ch.ready <= ~res_ch.ready;
			else res_ch.ready <= 1'b1;
		end
	end

	// end of run
	initial begin
		wait (stim_done);
		while (dist_q.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		if (fail_cnt == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

### layered_cubic_hermite_interp.f
rtl/core/lchi_pkg.sv
rtl/core/lchi_if.sv
rtl/core/lchi_front.sv
rtl/core/lchi_queue.sv
rtl/core/lchi_back.sv
rtl/core/layered_cubic_hermite_interp.sv
tb/layered_cubic_hermite_interp_tb.sv
